// ===== src/p4p_pkg.sv =====
// Shared types, constants and helpers for the packed 4bpp to planar converter.
// No dependencies.
package p4p_pkg;

    localparam int unsigned ROW_PIXELS_W       = 10;
    localparam int unsigned PIXEL_PAIR_W       = 8;
    localparam int unsigned PLANE_W            = 8;
    localparam int unsigned BYTE_INDEX_W       = 7;
    localparam int unsigned PAIR_CNT_W         = 9;
    localparam int unsigned RESET_ROW_PIXELS   = 640;
    localparam int unsigned MAX_ROW_PIXELS_DEF = 640;

    localparam logic [PLANE_W-1:0] FULL_MASK = 8'hFF;

    typedef logic [3:0] plane_code_t;

    // plane bits of one palette index: bit0 red, bit1 green, bit2 blue, bit3 intensity
    function automatic plane_code_t plane_code(input logic [3:0] idx);
        plane_code_t c;
        case (idx)
            4'd7:    c = 4'h8;
            4'd8:    c = 4'h7;
            default: c = idx;
        endcase
        return c;
    endfunction

    // clamp width to 1..max_pixels
    function automatic logic [ROW_PIXELS_W-1:0] eff_width(
        input logic [ROW_PIXELS_W-1:0] row,
        input int unsigned             max_pixels
    );
        logic [ROW_PIXELS_W-1:0] w;
        w = row;
        if (w == '0)
        begin
            w = ROW_PIXELS_W'(1);
        end
        if (32'(w) > max_pixels)
        begin
            w = max_pixels[ROW_PIXELS_W-1:0];
        end
        return w;
    endfunction

    function automatic logic [BYTE_INDEX_W-1:0] last_byte(input logic [ROW_PIXELS_W-1:0] w);
        logic [ROW_PIXELS_W-1:0] t;
        t = (w - ROW_PIXELS_W'(1)) >> 3;
        return t[BYTE_INDEX_W-1:0];
    endfunction

    function automatic logic [PLANE_W-1:0] last_mask(input logic [ROW_PIXELS_W-1:0] w);
        logic [2:0]         rem;
        logic [PLANE_W-1:0] m;
        rem = w[2:0];
        if (rem == 3'd0)
        begin
            m = FULL_MASK;
        end
        else
        begin
            m = FULL_MASK << (4'd8 - {1'b0, rem});
        end
        return m;
    endfunction

endpackage

// ===== src/p4p_if.sv =====
// Stream and config channel interfaces for the packed 4bpp to planar converter.
// Depends on p4p_pkg.
interface p4p_in_if;
    logic                             valid;
    logic                             ready;
    logic [p4p_pkg::PIXEL_PAIR_W-1:0] pixel_pair;

    modport source (output valid, output pixel_pair, input ready);
    modport sink   (input valid, input pixel_pair, output ready);
endinterface

interface p4p_out_if;
    logic                             valid;
    logic                             ready;
    logic [p4p_pkg::PLANE_W-1:0]      red_plane;
    logic [p4p_pkg::PLANE_W-1:0]      green_plane;
    logic [p4p_pkg::PLANE_W-1:0]      blue_plane;
    logic [p4p_pkg::PLANE_W-1:0]      intensity_plane;
    logic [p4p_pkg::BYTE_INDEX_W-1:0] plane_byte_index;
    logic [p4p_pkg::PLANE_W-1:0]      valid_mask;
    logic                             row_end;

    modport source (output valid, output red_plane, output green_plane, output blue_plane,
                    output intensity_plane, output plane_byte_index, output valid_mask,
                    output row_end, input ready);
    modport sink   (input valid, input red_plane, input green_plane, input blue_plane,
                    input intensity_plane, input plane_byte_index, input valid_mask,
                    input row_end, output ready);
endinterface

interface p4p_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [p4p_pkg::ROW_PIXELS_W-1:0] row_pixels;

    modport source (output valid, output row_pixels, input ready);
    modport sink   (input valid, input row_pixels, output ready);
endinterface

// ===== src/packed_4bpp_to_planar_converter.sv =====
// Top level: packed 4bpp pixel pairs in, red/green/blue/intensity plane bytes out.
// Depends on p4p_pkg and the interfaces in p4p_if.sv.
//
//   channel    dir  word                                          handshake
//   pixel_in   in   pixel_pair                                    valid/ready
//   plane_out  out  planes, plane_byte_index, valid_mask, row_end valid/ready
//   cfg        in   row_pixels                                    valid/ready, ready always 1
//
// One word per cycle in unless a stalled plane_out holds the input register;
// a group's fourth pair passes the input register, then the result register.
// Reset clears the shift registers and the column and loads a 640 pixel row.
// A stalled plane_out holds only the word in the input register that would
// complete the next plane byte; other words keep flowing into the shift registers.
module packed_4bpp_to_planar_converter #(
    parameter int unsigned MAX_ROW_PIXELS = p4p_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    p4p_in_if.sink     pixel_in,
    p4p_out_if.source  plane_out,
    p4p_cfg_if.sink    cfg
);

    localparam logic [p4p_pkg::ROW_PIXELS_W-1:0] RESET_EFF =
        p4p_pkg::eff_width(p4p_pkg::ROW_PIXELS_W'(p4p_pkg::RESET_ROW_PIXELS), MAX_ROW_PIXELS);

    logic [p4p_pkg::ROW_PIXELS_W-1:0] cfg_eff;

    logic [p4p_pkg::BYTE_INDEX_W-1:0] last_byte_reg;
    logic [p4p_pkg::PLANE_W-1:0]      last_mask_reg;

    logic                             s1_valid_reg;
    logic [p4p_pkg::PIXEL_PAIR_W-1:0] s1_pair_reg;

    logic [p4p_pkg::PLANE_W-1:0]      red_shift_reg;
    logic [p4p_pkg::PLANE_W-1:0]      green_shift_reg;
    logic [p4p_pkg::PLANE_W-1:0]      blue_shift_reg;
    logic [p4p_pkg::PLANE_W-1:0]      intensity_shift_reg;
    logic [p4p_pkg::PAIR_CNT_W-1:0]   pair_cnt_reg;

    logic [p4p_pkg::PLANE_W-1:0]      red_shift_next;
    logic [p4p_pkg::PLANE_W-1:0]      green_shift_next;
    logic [p4p_pkg::PLANE_W-1:0]      blue_shift_next;
    logic [p4p_pkg::PLANE_W-1:0]      intensity_shift_next;

    logic                             out_valid_reg;
    logic [p4p_pkg::PLANE_W-1:0]      out_red_reg;
    logic [p4p_pkg::PLANE_W-1:0]      out_green_reg;
    logic [p4p_pkg::PLANE_W-1:0]      out_blue_reg;
    logic [p4p_pkg::PLANE_W-1:0]      out_intensity_reg;
    logic [p4p_pkg::BYTE_INDEX_W-1:0] out_index_reg;
    logic [p4p_pkg::PLANE_W-1:0]      out_mask_reg;
    logic                             out_row_end_reg;

    p4p_pkg::plane_code_t             code_hi;
    p4p_pkg::plane_code_t             code_lo;
    logic [p4p_pkg::BYTE_INDEX_W-1:0] byte_idx;
    logic                             s1_emits;
    logic                             s1_advance;
    logic                             row_last;
    logic                             in_fire;
    logic                             cfg_fire;

    assign cfg.ready      = 1'b1;
    assign cfg_fire       = cfg.valid;
    assign cfg_eff        = p4p_pkg::eff_width(cfg.row_pixels, MAX_ROW_PIXELS);

    assign byte_idx       = pair_cnt_reg[p4p_pkg::PAIR_CNT_W-1:2];
    assign s1_emits       = (pair_cnt_reg[1:0] == 2'b11);
    assign row_last       = (byte_idx >= last_byte_reg);
    assign s1_advance     = s1_valid_reg && (!s1_emits || !out_valid_reg || plane_out.ready);
    assign pixel_in.ready = !s1_valid_reg || s1_advance;
    assign in_fire        = pixel_in.valid && pixel_in.ready;

    assign code_hi = p4p_pkg::plane_code(s1_pair_reg[7:4]);
    assign code_lo = p4p_pkg::plane_code(s1_pair_reg[3:0]);

    assign red_shift_next       = {red_shift_reg[5:0], code_hi[0], code_lo[0]};
    assign green_shift_next     = {green_shift_reg[5:0], code_hi[1], code_lo[1]};
    assign blue_shift_next      = {blue_shift_reg[5:0], code_hi[2], code_lo[2]};
    assign intensity_shift_next = {intensity_shift_reg[5:0], code_hi[3], code_lo[3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_byte_reg <= p4p_pkg::last_byte(RESET_EFF);
            last_mask_reg <= p4p_pkg::last_mask(RESET_EFF);
        end
        else if (cfg_fire)
        begin
            last_byte_reg <= p4p_pkg::last_byte(cfg_eff);
            last_mask_reg <= p4p_pkg::last_mask(cfg_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel_in.ready)
        begin
            s1_valid_reg <= pixel_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pair_reg <= pixel_in.pixel_pair;
        end
    end

    // shift registers and column; a config write restarts the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_shift_reg       <= '0;
            green_shift_reg     <= '0;
            blue_shift_reg      <= '0;
            intensity_shift_reg <= '0;
            pair_cnt_reg        <= '0;
        end
        else if (cfg_fire)
        begin
            red_shift_reg       <= '0;
            green_shift_reg     <= '0;
            blue_shift_reg      <= '0;
            intensity_shift_reg <= '0;
            pair_cnt_reg        <= '0;
        end
        else if (s1_advance)
        begin
            if (s1_emits && row_last)
            begin
                red_shift_reg       <= '0;
                green_shift_reg     <= '0;
                blue_shift_reg      <= '0;
                intensity_shift_reg <= '0;
                pair_cnt_reg        <= '0;
            end
            else
            begin
                red_shift_reg       <= red_shift_next;
                green_shift_reg     <= green_shift_next;
                blue_shift_reg      <= blue_shift_next;
                intensity_shift_reg <= intensity_shift_next;
                pair_cnt_reg        <= pair_cnt_reg + p4p_pkg::PAIR_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_emits)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (plane_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_emits)
        begin
            out_red_reg       <= red_shift_next;
            out_green_reg     <= green_shift_next;
            out_blue_reg      <= blue_shift_next;
            out_intensity_reg <= intensity_shift_next;
            out_index_reg     <= byte_idx;
            out_mask_reg      <= row_last ? last_mask_reg : p4p_pkg::FULL_MASK;
            out_row_end_reg   <= row_last;
        end
    end

    assign plane_out.valid            = out_valid_reg;
    assign plane_out.red_plane        = out_red_reg;
    assign plane_out.green_plane      = out_green_reg;
    assign plane_out.blue_plane       = out_blue_reg;
    assign plane_out.intensity_plane  = out_intensity_reg;
    assign plane_out.plane_byte_index = out_index_reg;
    assign plane_out.valid_mask       = out_mask_reg;
    assign plane_out.row_end          = out_row_end_reg;

endmodule

// ===== test/plane_word_checker.sv =====
`timescale 1ns / 1ps
// Checker for the packed 4bpp to planar converter: watches the pixel, plane and
// config channels, predicts every plane word and compares it on arrival.
// Depends on p4p_pkg and the channel interfaces in p4p_if.sv.
module plane_word_checker #(
    parameter int unsigned MAX_ROW_PIXELS = p4p_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    p4p_in_if           pixel_in,
    p4p_out_if          plane_out,
    p4p_cfg_if          cfg,
    output int unsigned errors,
    output int unsigned pending
);

    typedef struct packed {
        logic [p4p_pkg::PLANE_W-1:0]      red;
        logic [p4p_pkg::PLANE_W-1:0]      green;
        logic [p4p_pkg::PLANE_W-1:0]      blue;
        logic [p4p_pkg::PLANE_W-1:0]      inten;
        logic [p4p_pkg::BYTE_INDEX_W-1:0] index;
        logic [p4p_pkg::PLANE_W-1:0]      mask;
        logic                             row_end;
    } plane_word_t;

    plane_word_t                      plane_words_due[$];
    logic [p4p_pkg::ROW_PIXELS_W-1:0] width_reg;
    logic [p4p_pkg::PLANE_W-1:0]      red_sr;
    logic [p4p_pkg::PLANE_W-1:0]      green_sr;
    logic [p4p_pkg::PLANE_W-1:0]      blue_sr;
    logic [p4p_pkg::PLANE_W-1:0]      inten_sr;
    int unsigned                      column;

    // 7 and 8 swap: 7 is intensity only, 8 is red+green+blue
    function automatic p4p_pkg::plane_code_t index_planes(input logic [3:0] idx);
        if (idx == 4'd7)
        begin
            return 4'h8;
        end
        if (idx == 4'd8)
        begin
            return 4'h7;
        end
        return idx;
    endfunction

    task automatic restart_row();
        red_sr   = '0;
        green_sr = '0;
        blue_sr  = '0;
        inten_sr = '0;
        column   = 0;
    endtask

    task automatic shift_in(input logic [3:0] idx);
        p4p_pkg::plane_code_t c;
        c        = index_planes(idx);
        red_sr   = {red_sr[p4p_pkg::PLANE_W-2:0], c[0]};
        green_sr = {green_sr[p4p_pkg::PLANE_W-2:0], c[1]};
        blue_sr  = {blue_sr[p4p_pkg::PLANE_W-2:0], c[2]};
        inten_sr = {inten_sr[p4p_pkg::PLANE_W-2:0], c[3]};
    endtask

    task automatic convert_pair(input logic [p4p_pkg::PIXEL_PAIR_W-1:0] pair);
        int unsigned w;
        int unsigned rem;
        int unsigned padded;
        bit          last;
        plane_word_t pw;
        w = width_reg;
        if (w == 0)
        begin
            w = 1;
        end
        if (w > MAX_ROW_PIXELS)
        begin
            w = MAX_ROW_PIXELS;
        end
        rem    = w % 8;
        padded = (rem != 0) ? w + 8 - rem : w;
        shift_in(pair[7:4]);
        shift_in(pair[3:0]);
        if (column % 8 != 6)
        begin
            column += 2;
            return;
        end
        last       = (column + 2 >= padded);
        pw.red     = red_sr;
        pw.green   = green_sr;
        pw.blue    = blue_sr;
        pw.inten   = inten_sr;
        pw.index   = p4p_pkg::BYTE_INDEX_W'(column / 8);
        pw.mask    = (last && rem != 0) ? p4p_pkg::PLANE_W'(8'hFF << (8 - rem))
                                        : p4p_pkg::FULL_MASK;
        pw.row_end = last;
        plane_words_due.push_back(pw);
        if (last)
        begin
            restart_row();
        end
        else
        begin
            column += 2;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic compare_word();
        plane_word_t want;
        if (plane_words_due.size() == 0)
        begin
            $error("plane word with no expectation: index %0d", plane_out.plane_byte_index);
            errors++;
            return;
        end
        want = plane_words_due.pop_front();
        check_field("red_plane", want.red, plane_out.red_plane);
        check_field("green_plane", want.green, plane_out.green_plane);
        check_field("blue_plane", want.blue, plane_out.blue_plane);
        check_field("intensity_plane", want.inten, plane_out.intensity_plane);
        check_field("plane_byte_index", 8'(want.index), 8'(plane_out.plane_byte_index));
        check_field("valid_mask", want.mask, plane_out.valid_mask);
        check_field("row_end", 8'(want.row_end), 8'(plane_out.row_end));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg = p4p_pkg::ROW_PIXELS_W'(p4p_pkg::RESET_ROW_PIXELS);
            restart_row();
            plane_words_due.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (plane_out.valid && plane_out.ready)
            begin
                compare_word();
            end
            if (cfg.valid && cfg.ready)
            begin
                width_reg = cfg.row_pixels;
                restart_row();
            end
            if (pixel_in.valid && pixel_in.ready)
            begin
                convert_pair(pixel_in.pixel_pair);
            end
            pending = plane_words_due.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the packed 4bpp to planar converter: clock, reset, width
// writes and pixel stimulus with random idling; the checker does the compare.
// Depends on p4p_pkg, p4p_if.sv, plane_word_checker and the converter RTL.
module tb;

    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned CALM_ITEMS   = 150;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned SETTLE       = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic        clk;
    logic        rst_n;
    int unsigned errors;
    int unsigned pending;
    int unsigned cycle_count   = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_done    = 0;
    bit          calm          = 1'b0;
    logic [7:0]  burst[$];

    p4p_in_if  pix_ch();
    p4p_out_if plane_ch();
    p4p_cfg_if cfg_ch();

    packed_4bpp_to_planar_converter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pix_ch),
        .plane_out (plane_ch),
        .cfg       (cfg_ch)
    );

    plane_word_checker plane_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pix_ch),
        .plane_out (plane_ch),
        .cfg       (cfg_ch),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // plane word sink: random stalls, plus a long hold on request
    initial
    begin
        plane_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done++;
                plane_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 99) < 15)
            begin
                plane_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            plane_ch.ready <= 1'b1;
        end
    end

    task automatic send_pair(input logic [p4p_pkg::PIXEL_PAIR_W-1:0] pair);
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.pixel_pair <= pair;
        do
            @(posedge clk);
        while (!pix_ch.ready);
    endtask

    task automatic send_burst();
        foreach (burst[i])
        begin
            send_pair(burst[i]);
        end
    endtask

    // stop sending and wait until every plane word is out and the pipe is empty
    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_width(input logic [p4p_pkg::ROW_PIXELS_W-1:0] w);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.row_pixels <= w;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic int unsigned pick_width(input int unsigned phase);
        if (phase == 0)
        begin
            return 640;
        end
        if (phase == 1)
        begin
            return 1023;
        end
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(1, 7);
            2, 3, 4: return $urandom_range(8, 40);
            5, 6:    return $urandom_range(41, 120);
            7:       return 640;
            8:       return $urandom_range(641, 1023);
            default: return $urandom_range(1, 639);
        endcase
    endfunction

    function automatic int unsigned phase_items(input int unsigned w, input int unsigned phase);
        int unsigned eff;
        int unsigned per_row;
        eff = (w == 0) ? 1 : (w > p4p_pkg::MAX_ROW_PIXELS_DEF) ?
              p4p_pkg::MAX_ROW_PIXELS_DEF : w;
        per_row = ((eff + 7) / 8) * 4;
        if (phase == 0)
        begin
            return per_row + 20;
        end
        if (per_row <= 40)
        begin
            return per_row * $urandom_range(2, 8) + (($urandom_range(0, 1) != 0) ?
                   $urandom_range(1, 3) : 0);
        end
        return $urandom_range(20, 360);
    endfunction

    function automatic logic [p4p_pkg::PIXEL_PAIR_W-1:0] random_pair();
        if ($urandom_range(0, 9) == 0)
        begin
            case ($urandom_range(0, 5))
                0:       return 8'h77;
                1:       return 8'h88;
                2:       return 8'h78;
                3:       return 8'h87;
                4:       return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return p4p_pkg::PIXEL_PAIR_W'($urandom_range(0, 255));
    endfunction

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned phase;
        int unsigned n;
        int unsigned w;
        rst_n             = 1'b0;
        pix_ch.valid      = 1'b0;
        pix_ch.pixel_pair = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.row_pixels = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // all sixteen indices, the 7/8 swap, all-zero and all-one pairs
        write_width(10'd8);
        burst = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF,
                  8'h77, 8'h88, 8'h00, 8'hFF};
        send_burst();
        drain();
        // width 0 acts as 1
        write_width(10'd0);
        burst = '{8'hF0, 8'h0F, 8'h55, 8'hAA};
        send_burst();
        drain();
        // partial row, then a width write restarts it; 1023 saturates
        write_width(10'd13);
        burst = '{8'h78, 8'h87, 8'h12};
        send_burst();
        drain();
        write_width(10'd1023);
        burst = '{8'h34, 8'h56};
        send_burst();
        drain();
        // padded last byte with one real pixel
        write_width(10'd9);
        burst = '{8'h9A, 8'hBC, 8'hDE, 8'hF1, 8'h13, 8'h57, 8'h9B, 8'hDF};
        send_burst();
        drain();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            w = pick_width(phase);
            write_width(p4p_pkg::ROW_PIXELS_W'(w));
            n = phase_items(w, phase);
            if (n > RANDOM_ITEMS - sent)
            begin
                n = RANDOM_ITEMS - sent;
            end
            for (int unsigned k = 0; k < n; k++)
            begin
                if (phase == 2 && k == 0)
                begin
                    hold_requests++;
                end
                if (phase == 4 && k == n / 2)
                begin
                    drain();
                end
                if (sent >= RANDOM_ITEMS - CALM_ITEMS)
                begin
                    calm = 1'b1;
                end
                send_pair(random_pair());
                sent++;
            end
            drain();
            phase++;
        end

        repeat (16) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
